// ----- design/gpt_pkg.sv -----
package gpt_pkg;

  localparam int CoordWidthDefault = 11;
  localparam int JumpWidth         = 8;
  localparam logic [JumpWidth-1:0] JumpLimitReset = 8'd50;

  localparam int DeltaWidth  = 21;
  localparam int MagWidth    = 8;
  localparam int SquareWidth = 2 * MagWidth;
  localparam int CubeWidth   = 3 * MagWidth;

  // Division by 20 is a shift by two and a multiplication by ceil(2^25 / 5).
  localparam int DivShift    = 25;
  localparam int DivInWidth  = CubeWidth - 2;
  localparam int RecipWidth  = 23;
  localparam logic [RecipWidth-1:0] DivRecip = 23'd6710887;
  localparam int ProdWidth   = DivInWidth + RecipWidth;
  localparam int QuoWidth    = ProdWidth - DivShift;

  // Smallest magnitude whose cube exceeds 400.
  localparam logic [MagWidth-1:0] AccelMin = 8'd8;

  typedef enum logic [1:0] {
    BTN_NONE    = 2'd0,
    BTN_PRESS   = 2'd1,
    BTN_RELEASE = 2'd2
  } btn_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_CUBE,
    ST_SCALE,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic diff;
    logic square;
    logic cube;
    logic scale;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic move;
  } dp_status_t;

endpackage

// ----- design/gpt_in_if.sv -----
interface gpt_in_if #(
  parameter int COORD_WIDTH = gpt_pkg::CoordWidthDefault
);
  logic                   valid;
  logic                   ready;
  logic                   hand_present;
  logic                   mode_enable;
  logic [COORD_WIDTH-1:0] centroid_x;
  logic [COORD_WIDTH-1:0] centroid_y;
  logic                   thumb_shown;
  logic                   index_shown;
  logic                   turn_left;
  logic                   turn_right;

  modport source (
    output valid, hand_present, mode_enable, centroid_x, centroid_y,
           thumb_shown, index_shown, turn_left, turn_right,
    input  ready
  );

  modport sink (
    input  valid, hand_present, mode_enable, centroid_x, centroid_y,
           thumb_shown, index_shown, turn_left, turn_right,
    output ready
  );
endinterface

// ----- design/gpt_out_if.sv -----
interface gpt_out_if;
  import gpt_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         move_valid;
  logic signed [DeltaWidth-1:0] delta_x;
  logic signed [DeltaWidth-1:0] delta_y;
  logic                         wheel_up;
  logic                         wheel_down;
  logic [1:0]                   button_event;

  modport source (
    output valid, move_valid, delta_x, delta_y, wheel_up, wheel_down, button_event,
    input  ready
  );

  modport sink (
    input  valid, move_valid, delta_x, delta_y, wheel_up, wheel_down, button_event,
    output ready
  );
endinterface

// ----- design/gpt_cfg_if.sv -----
interface gpt_cfg_if;
  import gpt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [JumpWidth-1:0] jump_limit;

  modport source (
    output valid, jump_limit,
    input  ready
  );

  modport sink (
    input  valid, jump_limit,
    output ready
  );
endinterface

// ----- design/gpt_ctrl.sv -----
module gpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  gpt_pkg::dp_status_t status_i,
  output gpt_pkg::dp_cmd_t    cmd_o
);
  import gpt_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = status_i.move ? ST_SQUARE : ST_OUT;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_CUBE;
      end
      ST_CUBE: begin
        cmd_o.cube = 1'b1;
        state_d    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/gpt_datapath.sv -----
module gpt_datapath #(
  parameter int COORD_WIDTH = gpt_pkg::CoordWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gpt_pkg::dp_cmd_t                      cmd_i,
  output gpt_pkg::dp_status_t                   status_o,
  input  logic                                  cfg_we_i,
  input  logic [gpt_pkg::JumpWidth-1:0]         cfg_jump_limit_i,
  input  logic                                  hand_present_i,
  input  logic                                  mode_enable_i,
  input  logic [COORD_WIDTH-1:0]                centroid_x_i,
  input  logic [COORD_WIDTH-1:0]                centroid_y_i,
  input  logic                                  thumb_shown_i,
  input  logic                                  index_shown_i,
  input  logic                                  turn_left_i,
  input  logic                                  turn_right_i,
  output logic                                  move_valid_o,
  output logic signed [gpt_pkg::DeltaWidth-1:0] delta_x_o,
  output logic signed [gpt_pkg::DeltaWidth-1:0] delta_y_o,
  output logic                                  wheel_up_o,
  output logic                                  wheel_down_o,
  output logic [1:0]                            button_event_o
);
  import gpt_pkg::*;

  localparam int DiffWidth = COORD_WIDTH + 1;

  logic [JumpWidth-1:0]   jump_limit_q;
  logic [COORD_WIDTH-1:0] last_x_q, last_y_q;
  logic                   button_held_q;

  logic                   hand_q, mode_q, thumb_q, index_q, tl_q, tr_q;
  logic [COORD_WIDTH-1:0] cx_q, cy_q;

  logic                   move_q, wheel_up_q, wheel_down_q;
  btn_e                   btn_q;
  logic                   sign_x_q, sign_y_q;
  logic [MagWidth-1:0]    mag_x_q, mag_y_q;
  logic [SquareWidth-1:0] sq_x_q, sq_y_q;
  logic [CubeWidth-1:0]   cube_x_q, cube_y_q;
  logic [QuoWidth-1:0]    quo_x_q, quo_y_q;

  logic                   out_move_q, out_wheel_up_q, out_wheel_down_q;
  btn_e                   out_btn_q;
  logic [DeltaWidth-1:0]  out_dx_q, out_dy_q;

  logic                   idle_frame, jump, move_d;
  logic [COORD_WIDTH-1:0] prev_x, prev_y, abs_x, abs_y;
  logic [DiffWidth-1:0]   diff_x, diff_y;
  logic                   press, release_btn;
  logic [ProdWidth-1:0]   prod_x, prod_y;
  logic [QuoWidth-1:0]    acc_x, acc_y;
  logic [DeltaWidth-1:0]  dx_d, dy_d;

  always_comb begin
    idle_frame  = !hand_q || !mode_q;
    prev_x      = (last_x_q == '0) ? cx_q : last_x_q;
    prev_y      = (last_x_q == '0) ? cy_q : last_y_q;
    diff_x      = DiffWidth'(cx_q) - DiffWidth'(prev_x);
    diff_y      = DiffWidth'(cy_q) - DiffWidth'(prev_y);
    abs_x       = diff_x[DiffWidth-1] ? COORD_WIDTH'(-diff_x) : diff_x[COORD_WIDTH-1:0];
    abs_y       = diff_y[DiffWidth-1] ? COORD_WIDTH'(-diff_y) : diff_y[COORD_WIDTH-1:0];
    jump        = thumb_q && ((DiffWidth'(abs_x) > DiffWidth'(jump_limit_q)) ||
                              (DiffWidth'(abs_y) > DiffWidth'(jump_limit_q)));
    move_d      = !idle_frame && thumb_q && !jump;
    press       = !idle_frame && !jump && !index_q && !button_held_q;
    release_btn = !idle_frame && !jump && index_q && button_held_q;
  end

  assign status_o.move = move_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_limit_q  <= JumpLimitReset;
      last_x_q      <= '0;
      last_y_q      <= '0;
      button_held_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        jump_limit_q <= cfg_jump_limit_i;
      end
      if (cmd_i.diff) begin
        if (idle_frame) begin
          last_x_q <= '0;
        end else begin
          last_x_q <= cx_q;
          last_y_q <= cy_q;
        end
        if (press) begin
          button_held_q <= 1'b1;
        end else if (release_btn) begin
          button_held_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      hand_q  <= hand_present_i;
      mode_q  <= mode_enable_i;
      cx_q    <= centroid_x_i;
      cy_q    <= centroid_y_i;
      thumb_q <= thumb_shown_i;
      index_q <= index_shown_i;
      tl_q    <= turn_left_i;
      tr_q    <= turn_right_i;
    end
    if (cmd_i.diff) begin
      move_q       <= move_d;
      wheel_up_q   <= !idle_frame && !jump && tl_q;
      wheel_down_q <= !idle_frame && !jump && tr_q;
      btn_q        <= press ? BTN_PRESS : (release_btn ? BTN_RELEASE : BTN_NONE);
      sign_x_q     <= diff_x[DiffWidth-1];
      sign_y_q     <= diff_y[DiffWidth-1];
      mag_x_q      <= abs_x[MagWidth-1:0];
      mag_y_q      <= abs_y[MagWidth-1:0];
    end
    if (cmd_i.square) begin
      sq_x_q <= SquareWidth'(mag_x_q) * SquareWidth'(mag_x_q);
      sq_y_q <= SquareWidth'(mag_y_q) * SquareWidth'(mag_y_q);
    end
    if (cmd_i.cube) begin
      cube_x_q <= CubeWidth'(sq_x_q) * CubeWidth'(mag_x_q);
      cube_y_q <= CubeWidth'(sq_y_q) * CubeWidth'(mag_y_q);
    end
    if (cmd_i.scale) begin
      quo_x_q <= prod_x[ProdWidth-1:DivShift];
      quo_y_q <= prod_y[ProdWidth-1:DivShift];
    end
    if (cmd_i.load_out) begin
      out_move_q       <= move_q;
      out_dx_q         <= dx_d;
      out_dy_q         <= dy_d;
      out_wheel_up_q   <= wheel_up_q;
      out_wheel_down_q <= wheel_down_q;
      out_btn_q        <= btn_q;
    end
  end

  always_comb begin
    prod_x = ProdWidth'(cube_x_q[CubeWidth-1:2]) * ProdWidth'(DivRecip);
    prod_y = ProdWidth'(cube_y_q[CubeWidth-1:2]) * ProdWidth'(DivRecip);
    acc_x  = (mag_x_q >= AccelMin) ? quo_x_q : QuoWidth'(mag_x_q);
    acc_y  = (mag_y_q >= AccelMin) ? quo_y_q : QuoWidth'(mag_y_q);
    dx_d   = sign_x_q ? -DeltaWidth'(acc_x) : DeltaWidth'(acc_x);
    dy_d   = sign_y_q ? -DeltaWidth'(acc_y) : DeltaWidth'(acc_y);
    if (!move_q) begin
      dx_d = '0;
      dy_d = '0;
    end
  end

  assign move_valid_o   = out_move_q;
  assign delta_x_o      = out_dx_q;
  assign delta_y_o      = out_dy_q;
  assign wheel_up_o     = out_wheel_up_q;
  assign wheel_down_o   = out_wheel_down_q;
  assign button_event_o = out_btn_q;

endmodule

// ----- design/gesture_pointer_translator_top.sv -----
// Gesture pointer translator: each accepted frame beat yields exactly one event beat with the
// accelerated cursor move, wheel steps and left button press or release. A frame with a cursor
// move steps through capture, difference and jump check, square, cube, scaling by one
// twentieth and output load; a frame without a move goes from the difference and jump check
// straight to the output load. The controller steps each frame through one squaring and one
// cube multiplier per axis. A new frame is accepted while a finished event still waits at the
// output register. The jump_limit register resets to 50 and its port is always ready, so it
// must be written only while the block is idle.
module gesture_pointer_translator_top #(
  parameter int COORD_WIDTH = gpt_pkg::CoordWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gpt_in_if.sink    frame_in,
  gpt_out_if.source event_out,
  gpt_cfg_if.sink   cfg_in
);
  import gpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_in.ready = 1'b1;

  gpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_in.valid),
    .in_ready_o  (frame_in.ready),
    .out_valid_o (event_out.valid),
    .out_ready_i (event_out.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gpt_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_in.valid),
    .cfg_jump_limit_i (cfg_in.jump_limit),
    .hand_present_i   (frame_in.hand_present),
    .mode_enable_i    (frame_in.mode_enable),
    .centroid_x_i     (frame_in.centroid_x),
    .centroid_y_i     (frame_in.centroid_y),
    .thumb_shown_i    (frame_in.thumb_shown),
    .index_shown_i    (frame_in.index_shown),
    .turn_left_i      (frame_in.turn_left),
    .turn_right_i     (frame_in.turn_right),
    .move_valid_o     (event_out.move_valid),
    .delta_x_o        (event_out.delta_x),
    .delta_y_o        (event_out.delta_y),
    .wheel_up_o       (event_out.wheel_up),
    .wheel_down_o     (event_out.wheel_down),
    .button_event_o   (event_out.button_event)
  );

endmodule

// ----- design/gpt_checker.sv -----
module gpt_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_i,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic                                  move_valid_i,
  input logic signed [gpt_pkg::DeltaWidth-1:0] delta_x_i,
  input logic signed [gpt_pkg::DeltaWidth-1:0] delta_y_i
);
  import gpt_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("A second frame beat was taken while one is in flight.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !move_valid_i |-> delta_x_i == '0 && delta_y_i == '0)
    else $error("An event beat without a move carries a nonzero delta.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(delta_x_i) && $stable(delta_y_i))
    else $error("A stalled event beat changed or was dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("An event beat was withdrawn before it was taken.");

endmodule

bind gesture_pointer_translator_top gpt_checker u_gpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (frame_in.valid),
  .in_ready_i   (frame_in.ready),
  .out_valid_i  (event_out.valid),
  .out_ready_i  (event_out.ready),
  .move_valid_i (event_out.move_valid),
  .delta_x_i    (event_out.delta_x),
  .delta_y_i    (event_out.delta_y)
);
